>>> design/ecpsm_pkg.sv
// ----------------------------------------------------------------------------
// ecpsm_pkg
// Shared widths, operation codes and modular add/subtract helpers for the
// elliptic-curve point unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ecpsm_pkg;

  localparam int CW    = 16;
  localparam int SW    = 16;
  localparam int DW    = 2 * CW;
  localparam int CNT_W = $clog2(DW);
  localparam int SCNT_W = $clog2(SW + 1);

  localparam logic [1:0] OP_ADD  = 2'd0;
  localparam logic [1:0] OP_NEG  = 2'd1;
  localparam logic [1:0] OP_MUL  = 2'd2;
  localparam logic [1:0] OP_PASS = 2'd3;

  localparam logic [0:0] REG_CURVE_A = 1'b0;
  localparam logic [0:0] REG_MODULUS = 1'b1;

  localparam logic [CW-1:0] CURVE_A_RST = CW'(2);
  localparam logic [CW-1:0] MODULUS_RST = CW'(17);

  // u, v < m
  function automatic logic [CW-1:0] mod_add(input logic [CW-1:0] u, input logic [CW-1:0] v,
                                            input logic [CW-1:0] m);
    logic [CW:0] s;
    s = {1'b0, u} + {1'b0, v};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[CW-1:0];
  endfunction

  function automatic logic [CW-1:0] mod_sub(input logic [CW-1:0] u, input logic [CW-1:0] v,
                                            input logic [CW-1:0] m);
    logic [CW:0] s;
    if (u >= v) begin
      s = {1'b0, u} - {1'b0, v};
    end else begin
      s = {1'b0, u} + {1'b0, m} - {1'b0, v};
    end
    return s[CW-1:0];
  endfunction

endpackage

`default_nettype wire

>>> design/ecpsm_div.sv
// ----------------------------------------------------------------------------
// ecpsm_div
// Shared restoring divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ecpsm_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [ecpsm_pkg::DW-1:0]  dividend,
  input  wire logic [ecpsm_pkg::CW-1:0]  divisor,
  output logic                           busy,
  output logic                           done,
  output logic [ecpsm_pkg::DW-1:0]       quotient,
  output logic [ecpsm_pkg::CW-1:0]       remainder
);

  logic                            busy_r;
  logic                            done_r;
  logic [ecpsm_pkg::CNT_W-1:0]     cnt_r;
  logic [ecpsm_pkg::DW-1:0]        dvd_r;
  logic [ecpsm_pkg::CW-1:0]        dsr_r;
  logic [ecpsm_pkg::CW-1:0]        rem_r;
  logic [ecpsm_pkg::CW:0]          shifted;
  logic [ecpsm_pkg::CW:0]          diff;
  logic                            fits;

  always_comb begin
    shifted = {rem_r, dvd_r[ecpsm_pkg::DW-1]};
    fits    = shifted >= {1'b0, dsr_r};
    diff    = shifted - {1'b0, dsr_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        dvd_r  <= dividend;
        dsr_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= fits ? diff[ecpsm_pkg::CW-1:0] : shifted[ecpsm_pkg::CW-1:0];
        dvd_r <= {dvd_r[ecpsm_pkg::DW-2:0], fits};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == ecpsm_pkg::CNT_W'(ecpsm_pkg::DW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy      = busy_r;
  assign done      = done_r;
  assign quotient  = dvd_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

>>> design/ec_point_scalar_multiply.sv
// ----------------------------------------------------------------------------
// ec_point_scalar_multiply
// Affine point add / negate / pass / LSB-first double-and-add scalar multiply
// over a small prime field, sequenced around one shared multiply/divide unit.
// ----------------------------------------------------------------------------
//  channel  direction  handshake           payload
//  in       input      in_valid/in_ready   operation, points, scalar
//  out      output     out_valid/out_ready result point, infinity flag
//  cfg      input      cfg_write_en        cfg_index, cfg_data
//
//  Every multiply or reduction is one pass of the divider.
//  Input reduction: 5 passes. Point add: up to 4 passes plus 2 per Euclid step
//  of the inverse (at most about 24 steps).
//  Scalar multiply: SW rounds of up to two point adds.
//  in_ready is high only in idle; the result holds until out_ready.
//  Reset is synchronous: curve_a = 2, modulus = 17.
// ----------------------------------------------------------------------------
`default_nettype none

module ec_point_scalar_multiply (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [1:0]                in_operation,
  input  wire logic [ecpsm_pkg::CW-1:0]  in_first_x,
  input  wire logic [ecpsm_pkg::CW-1:0]  in_first_y,
  input  wire logic                      in_first_infinite,
  input  wire logic [ecpsm_pkg::CW-1:0]  in_second_x,
  input  wire logic [ecpsm_pkg::CW-1:0]  in_second_y,
  input  wire logic                      in_second_infinite,
  input  wire logic [ecpsm_pkg::SW-1:0]  in_scalar,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [ecpsm_pkg::CW-1:0]       out_result_x,
  output logic [ecpsm_pkg::CW-1:0]       out_result_y,
  output logic                           out_result_infinite,
  input  wire logic                      cfg_write_en,
  input  wire logic [0:0]                cfg_index,
  input  wire logic [ecpsm_pkg::CW-1:0]  cfg_data
);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_RED      = 5'd1;
  localparam logic [4:0] S_RED_W    = 5'd2;
  localparam logic [4:0] S_DISP     = 5'd3;
  localparam logic [4:0] S_MSTEP    = 5'd4;
  localparam logic [4:0] S_ADD      = 5'd5;
  localparam logic [4:0] S_DBL_W    = 5'd6;
  localparam logic [4:0] S_INV_INIT = 5'd7;
  localparam logic [4:0] S_INV      = 5'd8;
  localparam logic [4:0] S_INV_Q    = 5'd9;
  localparam logic [4:0] S_INV_M    = 5'd10;
  localparam logic [4:0] S_LAM_W    = 5'd11;
  localparam logic [4:0] S_LX_W     = 5'd12;
  localparam logic [4:0] S_Y_I      = 5'd13;
  localparam logic [4:0] S_Y_W      = 5'd14;
  localparam logic [4:0] S_END      = 5'd15;
  localparam logic [4:0] S_WAIT     = 5'd16;
  localparam logic [4:0] S_LOAD     = 5'd17;
  localparam logic [4:0] S_OUT      = 5'd18;

  localparam logic [1:0] CTX_OP  = 2'd0;
  localparam logic [1:0] CTX_ACC = 2'd1;
  localparam logic [1:0] CTX_DBL = 2'd2;

  localparam int CW = ecpsm_pkg::CW;
  localparam int DW = ecpsm_pkg::DW;

  logic [4:0]    state_r;
  logic [4:0]    ret_r;
  logic [1:0]    ctx_r;
  logic [2:0]    red_idx_r;
  logic [1:0]    op_r;
  logic [CW-1:0] curve_a_r, modulus_r;
  logic [CW-1:0] m_r, ca_r;
  logic [CW-1:0] p_x_r, p_y_r, q_x_r, q_y_r;
  logic          p_inf_r, q_inf_r;
  logic [CW-1:0] acc_x_r, acc_y_r;
  logic          acc_inf_r;
  logic [CW-1:0] u_x_r, u_y_r, v_x_r, v_y_r;
  logic          u_inf_r, v_inf_r;
  logic [CW-1:0] r_x_r, r_y_r;
  logic          r_inf_r;
  logic [CW-1:0] num_r, den_r, lam_r;
  logic [CW-1:0] e_r_r, e_nr_r, t_r, nt_r;
  logic [ecpsm_pkg::SW-1:0]     k_r;
  logic [ecpsm_pkg::SCNT_W-1:0] kcnt_r;
  logic          out_valid_r, out_inf_r;
  logic [CW-1:0] out_x_r, out_y_r;

  logic          div_start, div_busy, div_done;
  logic [DW-1:0] div_dvd, div_quot;
  logic [CW-1:0] div_dsr, div_rem;
  logic [CW-1:0] mul_a, mul_b;
  logic [CW-1:0] red_sel, inv_val;
  logic          is_neg, is_eq;

  ecpsm_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (div_dsr),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  always_comb begin
    case (red_idx_r)
      3'd0:    red_sel = p_x_r;
      3'd1:    red_sel = p_y_r;
      3'd2:    red_sel = q_x_r;
      3'd3:    red_sel = q_y_r;
      default: red_sel = ca_r;
    endcase
    is_neg  = (u_x_r == v_x_r) && (u_y_r == ecpsm_pkg::mod_sub('0, v_y_r, m_r));
    is_eq   = (u_x_r == v_x_r) && (u_y_r == v_y_r);
    inv_val = (e_r_r == CW'(1)) ? t_r : '0;
  end

  // one shared multiplier in front of the divider
  always_comb begin
    div_start = 1'b0;
    mul_a     = '0;
    mul_b     = CW'(1);
    div_dsr   = m_r;
    case (state_r)
      S_RED: begin
        div_start = 1'b1;
        mul_a     = red_sel;
      end
      S_ADD: begin
        div_start = !u_inf_r && !v_inf_r && !is_neg && is_eq;
        mul_a     = u_x_r;
        mul_b     = u_x_r;
      end
      S_INV: begin
        div_start = 1'b1;
        if (e_nr_r == '0) begin
          mul_a = num_r;
          mul_b = inv_val;
        end else begin
          mul_a   = e_r_r;
          div_dsr = e_nr_r;
        end
      end
      S_INV_Q: begin
        div_start = 1'b1;
        mul_a     = div_quot[CW-1:0];
        mul_b     = nt_r;
      end
      S_LAM_W: begin
        div_start = 1'b1;
        mul_a     = div_rem;
        mul_b     = div_rem;
      end
      S_Y_I: begin
        div_start = 1'b1;
        mul_a     = lam_r;
        mul_b     = ecpsm_pkg::mod_sub(u_x_r, r_x_r, m_r);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  assign div_dvd = DW'(mul_a) * DW'(mul_b);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      curve_a_r <= ecpsm_pkg::CURVE_A_RST;
      modulus_r <= ecpsm_pkg::MODULUS_RST;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        ecpsm_pkg::REG_CURVE_A: curve_a_r <= cfg_data;
        ecpsm_pkg::REG_MODULUS: modulus_r <= cfg_data;
        default:                curve_a_r <= curve_a_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r      <= in_operation;
            p_x_r     <= in_first_x;
            p_y_r     <= in_first_y;
            p_inf_r   <= in_first_infinite;
            q_x_r     <= in_second_x;
            q_y_r     <= in_second_y;
            q_inf_r   <= in_second_infinite;
            k_r       <= in_scalar;
            ca_r      <= curve_a_r;
            m_r       <= (modulus_r < CW'(2)) ? CW'(1) : modulus_r;
            red_idx_r <= '0;
            state_r   <= S_RED;
          end
        end
        S_RED: begin
          ret_r   <= S_RED_W;
          state_r <= S_WAIT;
        end
        S_RED_W: begin
          case (red_idx_r)
            3'd0:    p_x_r <= div_rem;
            3'd1:    p_y_r <= div_rem;
            3'd2:    q_x_r <= div_rem;
            3'd3:    q_y_r <= div_rem;
            default: ca_r  <= div_rem;
          endcase
          red_idx_r <= red_idx_r + 1'b1;
          state_r   <= (red_idx_r == 3'd4) ? S_DISP : S_RED;
        end
        S_DISP: begin
          unique case (op_r)
            ecpsm_pkg::OP_ADD: begin
              u_x_r <= p_x_r; u_y_r <= p_y_r; u_inf_r <= p_inf_r;
              v_x_r <= q_x_r; v_y_r <= q_y_r; v_inf_r <= q_inf_r;
              ctx_r   <= CTX_OP;
              state_r <= S_ADD;
            end
            ecpsm_pkg::OP_NEG: begin
              acc_x_r   <= p_x_r;
              acc_y_r   <= ecpsm_pkg::mod_sub('0, p_y_r, m_r);
              acc_inf_r <= p_inf_r;
              state_r   <= S_LOAD;
            end
            ecpsm_pkg::OP_MUL: begin
              acc_x_r   <= '0;
              acc_y_r   <= '0;
              acc_inf_r <= 1'b1;
              kcnt_r    <= '0;
              state_r   <= S_MSTEP;
            end
            default: begin
              acc_x_r   <= p_x_r;
              acc_y_r   <= p_y_r;
              acc_inf_r <= p_inf_r;
              state_r   <= S_LOAD;
            end
          endcase
        end
        S_MSTEP: begin
          if (kcnt_r == ecpsm_pkg::SCNT_W'(ecpsm_pkg::SW)) begin
            state_r <= S_LOAD;
          end else if (k_r[0]) begin
            u_x_r <= acc_x_r; u_y_r <= acc_y_r; u_inf_r <= acc_inf_r;
            v_x_r <= p_x_r;   v_y_r <= p_y_r;   v_inf_r <= p_inf_r;
            ctx_r   <= CTX_ACC;
            state_r <= S_ADD;
          end else begin
            u_x_r <= p_x_r; u_y_r <= p_y_r; u_inf_r <= p_inf_r;
            v_x_r <= p_x_r; v_y_r <= p_y_r; v_inf_r <= p_inf_r;
            ctx_r   <= CTX_DBL;
            state_r <= S_ADD;
          end
        end
        S_ADD: begin
          if (u_inf_r) begin
            r_x_r <= v_x_r; r_y_r <= v_y_r; r_inf_r <= v_inf_r;
            state_r <= S_END;
          end else if (v_inf_r) begin
            r_x_r <= u_x_r; r_y_r <= u_y_r; r_inf_r <= u_inf_r;
            state_r <= S_END;
          end else if (is_neg) begin
            r_x_r <= '0; r_y_r <= '0; r_inf_r <= 1'b1;
            state_r <= S_END;
          end else if (is_eq) begin
            ret_r   <= S_DBL_W;
            state_r <= S_WAIT;
          end else begin
            num_r   <= ecpsm_pkg::mod_sub(v_y_r, u_y_r, m_r);
            den_r   <= ecpsm_pkg::mod_sub(v_x_r, u_x_r, m_r);
            state_r <= S_INV_INIT;
          end
        end
        S_DBL_W: begin
          num_r <= ecpsm_pkg::mod_add(ecpsm_pkg::mod_add(ecpsm_pkg::mod_add(div_rem, div_rem,
                   m_r), div_rem, m_r), ca_r, m_r);
          den_r   <= ecpsm_pkg::mod_add(u_y_r, u_y_r, m_r);
          state_r <= S_INV_INIT;
        end
        S_INV_INIT: begin
          e_r_r   <= m_r;
          e_nr_r  <= den_r;
          t_r     <= '0;
          nt_r    <= CW'(1);
          state_r <= S_INV;
        end
        S_INV: begin
          ret_r   <= (e_nr_r == '0) ? S_LAM_W : S_INV_Q;
          state_r <= S_WAIT;
        end
        S_INV_Q: begin
          e_r_r   <= e_nr_r;
          e_nr_r  <= div_rem;
          ret_r   <= S_INV_M;
          state_r <= S_WAIT;
        end
        S_INV_M: begin
          t_r     <= nt_r;
          nt_r    <= ecpsm_pkg::mod_sub(t_r, div_rem, m_r);
          state_r <= S_INV;
        end
        S_LAM_W: begin
          lam_r   <= div_rem;
          ret_r   <= S_LX_W;
          state_r <= S_WAIT;
        end
        S_LX_W: begin
          r_x_r <= ecpsm_pkg::mod_sub(ecpsm_pkg::mod_sub(div_rem, u_x_r, m_r), v_x_r, m_r);
          state_r <= S_Y_I;
        end
        S_Y_I: begin
          ret_r   <= S_Y_W;
          state_r <= S_WAIT;
        end
        S_Y_W: begin
          r_y_r   <= ecpsm_pkg::mod_sub(div_rem, u_y_r, m_r);
          r_inf_r <= 1'b0;
          state_r <= S_END;
        end
        S_END: begin
          unique case (ctx_r)
            CTX_OP: begin
              acc_x_r <= r_x_r; acc_y_r <= r_y_r; acc_inf_r <= r_inf_r;
              state_r <= S_LOAD;
            end
            CTX_ACC: begin
              acc_x_r <= r_x_r; acc_y_r <= r_y_r; acc_inf_r <= r_inf_r;
              u_x_r <= p_x_r; u_y_r <= p_y_r; u_inf_r <= p_inf_r;
              v_x_r <= p_x_r; v_y_r <= p_y_r; v_inf_r <= p_inf_r;
              ctx_r   <= CTX_DBL;
              state_r <= S_ADD;
            end
            default: begin
              p_x_r <= r_x_r; p_y_r <= r_y_r; p_inf_r <= r_inf_r;
              k_r     <= k_r >> 1;
              kcnt_r  <= kcnt_r + 1'b1;
              state_r <= S_MSTEP;
            end
          endcase
        end
        S_WAIT: begin
          if (div_done) begin
            state_r <= ret_r;
          end
        end
        S_LOAD: begin
          out_x_r     <= acc_inf_r ? '0 : acc_x_r;
          out_y_r     <= acc_inf_r ? '0 : acc_y_r;
          out_inf_r   <= acc_inf_r;
          out_valid_r <= 1'b1;
          state_r     <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready            = (state_r == S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_result_x        = out_x_r;
  assign out_result_y        = out_y_r;
  assign out_result_infinite = out_inf_r;

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while a result is pending");

  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_inf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_infinite) |-> (out_result_x == '0 && out_result_y == '0))
    else $error("infinite result with nonzero coordinates");

  a_wait_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WAIT && !div_done) |-> div_busy)
    else $error("waiting on an idle divider");

endmodule

`default_nettype wire
